@@ rtl/look_direction_to_quaternion_top_defines.svh @@
// ----------------------------------------------------------------------------
// look direction to quaternion assertion macros
// concurrent assertion wrappers, empty bodies for synthesis
// ----------------------------------------------------------------------------
`ifndef LOOK_DIRECTION_TO_QUATERNION_TOP_DEFINES_SVH
`define LOOK_DIRECTION_TO_QUATERNION_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// checked while out of reset
`define LDQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ldq assertion failed");
// checked during reset too
`define LDQ_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ldq reset assertion failed");
`else
`define LDQ_ASSERT(lbl, clk, rst_n, prop)
`define LDQ_ASSERT_RST(lbl, clk, prop)
`endif

`endif

@@ rtl/ldq_pkg.sv @@
// ----------------------------------------------------------------------------
// ldq_pkg
// shared constants, stage types and step functions for the look rotation pipe
// ----------------------------------------------------------------------------
package ldq_pkg;

    localparam int KBITS     = 30;
    localparam int MW        = 31;
    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 31;
    // lzc (3) + align + square + sum, root steps, divide setup, divide steps, sign
    localparam int NORM_LAT  = 6 + SQ_STEPS + 1 + DIV_STEPS + 1;
    localparam longint KONE  = 64'd1 << KBITS;

    localparam logic [1:0] BR_W = 2'd0;
    localparam logic [1:0] BR_X = 2'd1;
    localparam logic [1:0] BR_Y = 2'd2;
    localparam logic [1:0] BR_Z = 2'd3;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] res;
    } t_sq;

    typedef struct packed {
        logic [33:0] rem;
        logic [30:0] low;
        logic [30:0] quo;
    } t_div;

    // one step of the digit-by-digit square root, bit = 4^(31-k)
    function automatic t_sq sq_step(input t_sq s, input int k);
        logic [63:0] bitv;
        logic [63:0] trial;
        t_sq         o;
        bitv  = 64'd1 << (62 - 2 * k);
        trial = s.res + bitv;
        if (s.v >= trial) begin
            o.v   = s.v - trial;
            o.res = (s.res >> 1) + bitv;
        end else begin
            o.v   = s.v;
            o.res = s.res >> 1;
        end
        return o;
    endfunction

    // one restoring division step, one quotient bit
    function automatic t_div div_step(input t_div d, input logic [32:0] den);
        logic [33:0] t;
        t_div        o;
        t     = {d.rem[32:0], d.low[30]};
        o.low = {d.low[29:0], 1'b0};
        if (t >= {1'b0, den}) begin
            o.rem = t - {1'b0, den};
            o.quo = {d.quo[29:0], 1'b1};
        end else begin
            o.rem = t;
            o.quo = {d.quo[29:0], 1'b0};
        end
        return o;
    endfunction

endpackage

@@ rtl/ldq_norm3.sv @@
// ----------------------------------------------------------------------------
// ldq_norm3
// pipelined 3-vector normalizer, unit length scaled to 2^30
// ----------------------------------------------------------------------------
module ldq_norm3 import ldq_pkg::*; #(
    parameter int VW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [VW-1:0] i_vec [3],
    output logic signed [31:0]   o_vec [3]
);

    localparam int NG   = (VW + 7) / 8;
    localparam int PADW = NG * 8;
    localparam int PW   = $clog2(PADW);

    logic [VW-1:0]   w_raw   [3];
    logic [VW-1:0]   n_a_mag [3];
    logic [2:0]      n_a_sgn;
    logic [VW-1:0]   n_a_mx;
    logic [VW-1:0]   r_a_mag [3];
    logic [2:0]      r_a_sgn;
    logic [VW-1:0]   r_a_mx;

    logic [PADW-1:0] n_pad;
    logic [NG-1:0]   n_gany;
    logic [2:0]      n_gpos  [NG];
    logic [NG-1:0]   r_gany;
    logic [2:0]      r_gpos  [NG];
    logic [VW-1:0]   r_b1_mag [3];
    logic [2:0]      r_b1_sgn;

    logic [PW-1:0]   n_p;
    logic            n_zero;
    logic [PW-1:0]   r_p;
    logic [VW-1:0]   r_b2_mag [3];
    logic [3:0]      r_b2_sz;

    logic [VW+KBITS-1:0] n_wide [3];
    logic [MW-1:0]   r_c_m  [3];
    logic [3:0]      r_c_sz;
    logic [61:0]     r_d_sq [3];
    logic [MW-1:0]   r_d_m  [3];
    logic [3:0]      r_d_sz;
    logic [63:0]     r_e_sum;
    logic [MW-1:0]   r_e_m  [3];
    logic [3:0]      r_e_sz;

    t_sq             r_sq   [SQ_STEPS];
    logic [MW-1:0]   r_sq_m [SQ_STEPS][3];
    logic [3:0]      r_sq_sz [SQ_STEPS];

    logic [31:0]     w_len;
    logic [61:0]     n_num [3];
    t_div            n_f_div [3];
    t_div            r_dv    [DIV_STEPS][3];
    logic [32:0]     r_dv_den [DIV_STEPS];
    logic [3:0]      r_dv_sz  [DIV_STEPS];
    t_div            r_f_div [3];
    logic [32:0]     r_f_den;
    logic [3:0]      r_f_sz;

    // magnitudes and largest magnitude
    always_comb begin
        n_a_mx = '0;
        for (int i = 0; i < 3; i++) begin
            w_raw[i]   = i_vec[i];
            n_a_sgn[i] = w_raw[i][VW-1];
            n_a_mag[i] = w_raw[i][VW-1] ? (~w_raw[i] + 1'b1) : w_raw[i];
            if (n_a_mag[i] > n_a_mx) n_a_mx = n_a_mag[i];
        end
    end

    // leading one, first per byte group
    always_comb begin
        n_pad = PADW'(r_a_mx);
        for (int g = 0; g < NG; g++) begin
            n_gany[g] = |n_pad[g*8 +: 8];
            n_gpos[g] = '0;
            for (int b = 0; b < 8; b++) begin
                if (n_pad[g*8+b]) n_gpos[g] = 3'(b);
            end
        end
    end

    // then across groups
    always_comb begin
        n_p    = '0;
        n_zero = 1'b1;
        for (int g = 0; g < NG; g++) begin
            if (r_gany[g]) begin
                n_p    = PW'(g * 8) + PW'(r_gpos[g]);
                n_zero = 1'b0;
            end
        end
    end

    // align so the largest magnitude lands in [2^30, 2^31)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_wide[i] = {r_b2_mag[i], {KBITS{1'b0}}} >> r_p;
        end
    end

    // divide setup, rounded quotient of m * 2^30 / len
    always_comb begin
        w_len = r_sq[SQ_STEPS-1].res[31:0];
        for (int i = 0; i < 3; i++) begin
            n_num[i]       = 62'({r_sq_m[SQ_STEPS-1][i], {KBITS{1'b0}}}) + 62'(w_len[31:1]);
            n_f_div[i].rem = 34'(n_num[i][61:31]);
            n_f_div[i].low = n_num[i][30:0];
            n_f_div[i].quo = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mag  <= n_a_mag;
            r_a_sgn  <= n_a_sgn;
            r_a_mx   <= n_a_mx;

            r_gany   <= n_gany;
            r_gpos   <= n_gpos;
            r_b1_mag <= r_a_mag;
            r_b1_sgn <= r_a_sgn;

            r_p      <= n_p;
            r_b2_mag <= r_b1_mag;
            r_b2_sz  <= {n_zero, r_b1_sgn};

            for (int i = 0; i < 3; i++) begin
                r_c_m[i]  <= n_wide[i][MW-1:0];
                r_d_sq[i] <= r_c_m[i] * r_c_m[i];
            end
            r_c_sz  <= r_b2_sz;
            r_d_m   <= r_c_m;
            r_d_sz  <= r_c_sz;

            r_e_sum <= 64'(r_d_sq[0]) + 64'(r_d_sq[1]) + 64'(r_d_sq[2]);
            r_e_m   <= r_d_m;
            r_e_sz  <= r_d_sz;

            r_sq[0]    <= sq_step({r_e_sum, 64'd0}, 0);
            r_sq_m[0]  <= r_e_m;
            r_sq_sz[0] <= r_e_sz;
            for (int k = 1; k < SQ_STEPS; k++) begin
                r_sq[k]    <= sq_step(r_sq[k-1], k);
                r_sq_m[k]  <= r_sq_m[k-1];
                r_sq_sz[k] <= r_sq_sz[k-1];
            end

            r_f_div <= n_f_div;
            r_f_den <= {1'b0, w_len};
            r_f_sz  <= r_sq_sz[SQ_STEPS-1];

            for (int i = 0; i < 3; i++) begin
                r_dv[0][i] <= div_step(r_f_div[i], r_f_den);
            end
            r_dv_den[0] <= r_f_den;
            r_dv_sz[0]  <= r_f_sz;
            for (int k = 1; k < DIV_STEPS; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r_dv[k][i] <= div_step(r_dv[k-1][i], r_dv_den[k-1]);
                end
                r_dv_den[k] <= r_dv_den[k-1];
                r_dv_sz[k]  <= r_dv_sz[k-1];
            end

            // sign back in, zero vector gives zero
            for (int i = 0; i < 3; i++) begin
                if (r_dv_sz[DIV_STEPS-1][3]) begin
                    o_vec[i] <= '0;
                end else if (r_dv_sz[DIV_STEPS-1][i]) begin
                    o_vec[i] <= -$signed({1'b0, r_dv[DIV_STEPS-1][i].quo});
                end else begin
                    o_vec[i] <= $signed({1'b0, r_dv[DIV_STEPS-1][i].quo});
                end
            end
        end
    end

endmodule

@@ rtl/look_direction_to_quaternion_top.sv @@
// throughput: one beat per cycle while not stalled, every stage is a register of the pipe
// latency is set mostly by the one-bit-per-stage square root and divide stages
// an output beat held by stall freezes the whole pipe, nothing is lost
// reset clears only the valid bits, data registers are not reset
// ----------------------------------------------------------------------------
// look_direction_to_quaternion_top
// forward and up vectors to a look rotation quaternion in Q1.FRAC_BITS
// ----------------------------------------------------------------------------
`include "look_direction_to_quaternion_top_defines.svh"

module look_direction_to_quaternion_top import ldq_pkg::*; #(
    parameter int IN_WIDTH  = 16,
    parameter int FRAC_BITS = 14
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [IN_WIDTH-1:0]   i_fwd_x,
    input  logic signed [IN_WIDTH-1:0]   i_fwd_y,
    input  logic signed [IN_WIDTH-1:0]   i_fwd_z,
    input  logic signed [IN_WIDTH-1:0]   i_up_x,
    input  logic signed [IN_WIDTH-1:0]   i_up_y,
    input  logic signed [IN_WIDTH-1:0]   i_up_z,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [FRAC_BITS+1:0]  o_quat_x,
    output logic signed [FRAC_BITS+1:0]  o_quat_y,
    output logic signed [FRAC_BITS+1:0]  o_quat_z,
    output logic signed [FRAC_BITS+1:0]  o_quat_w,
    output logic                         o_degenerate
);

    localparam int IW     = IN_WIDTH;
    localparam int CW     = 2 * IN_WIDTH + 1;   // up x forward components
    localparam int RW     = 63;                 // fh x rh components
    localparam int OW     = FRAC_BITS + 2;
    localparam int SH     = KBITS - FRAC_BITS;
    localparam int HALF   = (SH > 0) ? (1 << (SH - 1)) : 0;
    localparam int ONE_Q  = 1 << FRAC_BITS;
    localparam int FR_DLY = 2 + NORM_LAT;
    // input, cross, normalize, cross, normalize, trace, branch, root, setup, divide, pack
    localparam int LAT    = 3 + NORM_LAT + 2 + NORM_LAT + 2 + SQ_STEPS + 1 + DIV_STEPS + 1;

    localparam logic signed [OW-1:0] OUT_ONE  = OW'(ONE_Q);
    localparam logic signed [OW-1:0] OUT_MONE = -OW'(ONE_Q);

    typedef struct packed {
        logic [1:0]  br;
        logic [31:0] piv;
        logic [2:0]  ovf;
        logic [2:0]  sgn;
    } t_qside;

    // flow control: the pipe moves unless a finished beat is held
    logic                 w_en;
    logic [LAT-1:0]       r_vld;

    // front end, cross product up x forward
    logic signed [IW-1:0]   r_p0_f [3];
    logic signed [IW-1:0]   r_p0_u [3];
    logic signed [2*IW-1:0] r_p1_pr [6];
    logic signed [IW-1:0]   r_p1_f [3];
    logic signed [CW-1:0]   n_p2_c [3];
    logic                   n_p2_deg;
    logic signed [CW-1:0]   r_p2_c [3];
    logic signed [IW-1:0]   r_p2_f [3];
    logic                   r_p2_deg;
    logic                   r_deg_dly [LAT-4];

    logic signed [31:0]     w_fh [3];
    logic signed [31:0]     w_rh [3];
    logic signed [31:0]     w_uh [3];

    // second cross product, forward x right
    logic signed [63:0]     r_p3_pr [6];
    logic signed [RW-1:0]   r_p4_r  [3];
    logic signed [31:0]     r_fr_dly [FR_DLY][6];

    // matrix to quaternion
    logic signed [31:0]     r_q0_m [9];
    logic signed [33:0]     r_q0_tr;
    logic [1:0]             n_q1_br;
    logic signed [34:0]     n_q1_rad;
    logic signed [32:0]     n_q1_d [3];
    logic [1:0]             r_q1_br;
    logic signed [34:0]     r_q1_rad;
    logic signed [32:0]     r_q1_d [3];
    logic [32:0]            w_radu;

    t_sq                    r_qs    [SQ_STEPS];
    logic [1:0]             r_qs_br [SQ_STEPS];
    logic signed [32:0]     r_qs_d  [SQ_STEPS][3];

    logic [31:0]            n_qf_n;
    logic [32:0]            n_qf_mag [3];
    logic [61:0]            n_qf_num [3];
    t_div                   n_qf_div [3];
    t_qside                 n_qf_side;
    t_div                   r_qf_div [3];
    logic [32:0]            r_qf_den;
    t_qside                 r_qf_side;

    t_div                   r_qd      [DIV_STEPS][3];
    logic [32:0]            r_qd_den  [DIV_STEPS];
    t_qside                 r_qd_side [DIV_STEPS];

    logic [OW-1:0]          n_pk_d [3];
    logic [OW-1:0]          n_pk_p;
    logic [OW-1:0]          n_out [4];
    logic [OW-1:0]          r_out [4];
    logic                   r_out_deg;

    // round to FRAC_BITS and saturate to +-1.0
    function automatic logic [OW-1:0] pack_q(input logic [31:0] q, input logic sat,
                                             input logic neg);
        logic [32:0] m;
        m = (33'(q) + 33'(HALF)) >> SH;
        if (sat || (m > 33'(ONE_Q))) m = 33'(ONE_Q);
        return neg ? OW'(-m) : OW'(m);
    endfunction

    assign w_en    = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // up x forward and the degenerate test
    always_comb begin
        n_p2_c[0] = CW'(r_p1_pr[0]) - CW'(r_p1_pr[1]);
        n_p2_c[1] = CW'(r_p1_pr[2]) - CW'(r_p1_pr[3]);
        n_p2_c[2] = CW'(r_p1_pr[4]) - CW'(r_p1_pr[5]);
        n_p2_deg  = ((r_p1_f[0] == '0) && (r_p1_f[1] == '0) && (r_p1_f[2] == '0)) ||
                    ((n_p2_c[0] == '0) && (n_p2_c[1] == '0) && (n_p2_c[2] == '0));
    end

    ldq_norm3 #(.VW(IW)) u_norm_fwd (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_vec (r_p2_f),
        .o_vec (w_fh)
    );

    ldq_norm3 #(.VW(CW)) u_norm_right (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_vec (r_p2_c),
        .o_vec (w_rh)
    );

    ldq_norm3 #(.VW(RW)) u_norm_up (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_vec (r_p4_r),
        .o_vec (w_uh)
    );

    // branch pick: positive trace first, else the largest diagonal term
    always_comb begin
        if (r_q0_tr > 0) begin
            n_q1_br   = BR_W;
            n_q1_rad  = 35'(r_q0_tr) + 35'(KONE);
            n_q1_d[0] = 33'(r_q0_m[5]) - 33'(r_q0_m[7]);
            n_q1_d[1] = 33'(r_q0_m[6]) - 33'(r_q0_m[2]);
            n_q1_d[2] = 33'(r_q0_m[1]) - 33'(r_q0_m[3]);
        end else if ((r_q0_m[0] >= r_q0_m[4]) && (r_q0_m[0] >= r_q0_m[8])) begin
            n_q1_br   = BR_X;
            n_q1_rad  = 35'(KONE) + 35'(r_q0_m[0]) - 35'(r_q0_m[4]) - 35'(r_q0_m[8]);
            n_q1_d[0] = 33'(r_q0_m[1]) + 33'(r_q0_m[3]);
            n_q1_d[1] = 33'(r_q0_m[2]) + 33'(r_q0_m[6]);
            n_q1_d[2] = 33'(r_q0_m[5]) - 33'(r_q0_m[7]);
        end else if (r_q0_m[4] > r_q0_m[8]) begin
            n_q1_br   = BR_Y;
            n_q1_rad  = 35'(KONE) + 35'(r_q0_m[4]) - 35'(r_q0_m[0]) - 35'(r_q0_m[8]);
            n_q1_d[0] = 33'(r_q0_m[3]) + 33'(r_q0_m[1]);
            n_q1_d[1] = 33'(r_q0_m[7]) + 33'(r_q0_m[5]);
            n_q1_d[2] = 33'(r_q0_m[6]) - 33'(r_q0_m[2]);
        end else begin
            n_q1_br   = BR_Z;
            n_q1_rad  = 35'(KONE) + 35'(r_q0_m[8]) - 35'(r_q0_m[0]) - 35'(r_q0_m[4]);
            n_q1_d[0] = 33'(r_q0_m[6]) + 33'(r_q0_m[2]);
            n_q1_d[1] = 33'(r_q0_m[7]) + 33'(r_q0_m[5]);
            n_q1_d[2] = 33'(r_q0_m[1]) - 33'(r_q0_m[3]);
        end
    end

    // a radicand pushed below zero by rounding counts as zero
    assign w_radu = r_q1_rad[34] ? 33'd0 : r_q1_rad[32:0];

    // pivot root, divisor 2n, rounded numerators |d| * 2^30 + n
    always_comb begin
        n_qf_n = r_qs[SQ_STEPS-1].res[31:0];
        if (n_qf_n == '0) n_qf_n = 32'd1;
        n_qf_side.br  = r_qs_br[SQ_STEPS-1];
        n_qf_side.piv = 32'((33'(n_qf_n) + 33'd1) >> 1);
        for (int j = 0; j < 3; j++) begin
            n_qf_side.sgn[j] = r_qs_d[SQ_STEPS-1][j][32];
            n_qf_mag[j]      = n_qf_side.sgn[j] ? 33'(-r_qs_d[SQ_STEPS-1][j])
                                                : 33'(r_qs_d[SQ_STEPS-1][j]);
            n_qf_num[j]      = 62'({n_qf_mag[j][31:0], {KBITS{1'b0}}}) + 62'(n_qf_n);
            // quotient of 2^31 or more is far past saturation
            n_qf_side.ovf[j] = 33'(n_qf_num[j][61:31]) >= {n_qf_n, 1'b0};
            n_qf_div[j].rem  = 34'(n_qf_num[j][61:31]);
            n_qf_div[j].low  = n_qf_num[j][30:0];
            n_qf_div[j].quo  = '0;
        end
    end

    // output rounding and placement of the pivot term
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_pk_d[j] = pack_q(32'(r_qd[DIV_STEPS-1][j].quo),
                               r_qd_side[DIV_STEPS-1].ovf[j],
                               r_qd_side[DIV_STEPS-1].sgn[j]);
        end
        n_pk_p = pack_q(r_qd_side[DIV_STEPS-1].piv, 1'b0, 1'b0);
        unique case (r_qd_side[DIV_STEPS-1].br)
            BR_W: begin
                n_out[0] = n_pk_d[0];
                n_out[1] = n_pk_d[1];
                n_out[2] = n_pk_d[2];
                n_out[3] = n_pk_p;
            end
            BR_X: begin
                n_out[0] = n_pk_p;
                n_out[1] = n_pk_d[0];
                n_out[2] = n_pk_d[1];
                n_out[3] = n_pk_d[2];
            end
            BR_Y: begin
                n_out[0] = n_pk_d[0];
                n_out[1] = n_pk_p;
                n_out[2] = n_pk_d[1];
                n_out[3] = n_pk_d[2];
            end
            default: begin
                n_out[0] = n_pk_d[0];
                n_out[1] = n_pk_d[1];
                n_out[2] = n_pk_p;
                n_out[3] = n_pk_d[2];
            end
        endcase
        // zero or parallel input gives identity
        if (r_deg_dly[LAT-5]) begin
            n_out[0] = '0;
            n_out[1] = '0;
            n_out[2] = '0;
            n_out[3] = OUT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // input beat capture
            r_p0_f <= '{i_fwd_x, i_fwd_y, i_fwd_z};
            r_p0_u <= '{i_up_x, i_up_y, i_up_z};

            r_p1_pr[0] <= r_p0_u[1] * r_p0_f[2];
            r_p1_pr[1] <= r_p0_u[2] * r_p0_f[1];
            r_p1_pr[2] <= r_p0_u[2] * r_p0_f[0];
            r_p1_pr[3] <= r_p0_u[0] * r_p0_f[2];
            r_p1_pr[4] <= r_p0_u[0] * r_p0_f[1];
            r_p1_pr[5] <= r_p0_u[1] * r_p0_f[0];
            r_p1_f     <= r_p0_f;

            r_p2_c   <= n_p2_c;
            r_p2_f   <= r_p1_f;
            r_p2_deg <= n_p2_deg;

            r_deg_dly[0] <= r_p2_deg;
            for (int k = 1; k < LAT - 4; k++) begin
                r_deg_dly[k] <= r_deg_dly[k-1];
            end

            // forward x right gives the new up
            r_p3_pr[0] <= w_fh[1] * w_rh[2];
            r_p3_pr[1] <= w_fh[2] * w_rh[1];
            r_p3_pr[2] <= w_fh[2] * w_rh[0];
            r_p3_pr[3] <= w_fh[0] * w_rh[2];
            r_p3_pr[4] <= w_fh[0] * w_rh[1];
            r_p3_pr[5] <= w_fh[1] * w_rh[0];

            r_p4_r[0] <= RW'(r_p3_pr[0]) - RW'(r_p3_pr[1]);
            r_p4_r[1] <= RW'(r_p3_pr[2]) - RW'(r_p3_pr[3]);
            r_p4_r[2] <= RW'(r_p3_pr[4]) - RW'(r_p3_pr[5]);

            // forward and right wait for the up normalizer
            r_fr_dly[0] <= '{w_fh[0], w_fh[1], w_fh[2], w_rh[0], w_rh[1], w_rh[2]};
            for (int k = 1; k < FR_DLY; k++) begin
                r_fr_dly[k] <= r_fr_dly[k-1];
            end

            // matrix rows right, up, forward
            r_q0_m[0] <= r_fr_dly[FR_DLY-1][3];
            r_q0_m[1] <= r_fr_dly[FR_DLY-1][4];
            r_q0_m[2] <= r_fr_dly[FR_DLY-1][5];
            r_q0_m[3] <= w_uh[0];
            r_q0_m[4] <= w_uh[1];
            r_q0_m[5] <= w_uh[2];
            r_q0_m[6] <= r_fr_dly[FR_DLY-1][0];
            r_q0_m[7] <= r_fr_dly[FR_DLY-1][1];
            r_q0_m[8] <= r_fr_dly[FR_DLY-1][2];
            r_q0_tr   <= 34'(r_fr_dly[FR_DLY-1][3]) + 34'(w_uh[1]) +
                         34'(r_fr_dly[FR_DLY-1][2]);

            r_q1_br  <= n_q1_br;
            r_q1_rad <= n_q1_rad;
            r_q1_d   <= n_q1_d;

            // root of radicand * 2^30, one result bit per stage
            r_qs[0]    <= sq_step({64'(w_radu) << KBITS, 64'd0}, 0);
            r_qs_br[0] <= r_q1_br;
            r_qs_d[0]  <= r_q1_d;
            for (int k = 1; k < SQ_STEPS; k++) begin
                r_qs[k]    <= sq_step(r_qs[k-1], k);
                r_qs_br[k] <= r_qs_br[k-1];
                r_qs_d[k]  <= r_qs_d[k-1];
            end

            r_qf_div  <= n_qf_div;
            r_qf_den  <= {n_qf_n, 1'b0};
            r_qf_side <= n_qf_side;

            for (int j = 0; j < 3; j++) begin
                r_qd[0][j] <= div_step(r_qf_div[j], r_qf_den);
            end
            r_qd_den[0]  <= r_qf_den;
            r_qd_side[0] <= r_qf_side;
            for (int k = 1; k < DIV_STEPS; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_qd[k][j] <= div_step(r_qd[k-1][j], r_qd_den[k-1]);
                end
                r_qd_den[k]  <= r_qd_den[k-1];
                r_qd_side[k] <= r_qd_side[k-1];
            end

            // output register
            r_out     <= n_out;
            r_out_deg <= r_deg_dly[LAT-5];
        end
    end

    assign o_quat_x     = r_out[0];
    assign o_quat_y     = r_out[1];
    assign o_quat_z     = r_out[2];
    assign o_quat_w     = r_out[3];
    assign o_degenerate = r_out_deg;

    `LDQ_ASSERT(a_deg_identity, i_clk, i_rst_n, (o_valid && o_degenerate) |-> ((o_quat_w == OUT_ONE) && (o_quat_x == '0) && (o_quat_y == '0) && (o_quat_z == '0)))
    `LDQ_ASSERT(a_x_range, i_clk, i_rst_n, o_valid |-> ((o_quat_x <= OUT_ONE) && (o_quat_x >= OUT_MONE)))
    `LDQ_ASSERT(a_w_range, i_clk, i_rst_n, o_valid |-> ((o_quat_w <= OUT_ONE) && (o_quat_w >= OUT_MONE)))
    `LDQ_ASSERT(a_pivot_nonzero, i_clk, i_rst_n, (o_valid && !o_degenerate) |-> ((o_quat_x != '0) || (o_quat_y != '0) || (o_quat_z != '0) || (o_quat_w != '0)))
    `LDQ_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !o_valid)

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the look rotation pipe: a directed table then random
// vector pairs, checked against typed-in results or a bit-exact fixed-point predictor
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  N_RANDOM  = 1530;
    localparam int  QUIET_TAIL = 150;     // no idling for the last beats
    localparam int  LATENCY   = 214;
    localparam int  LIMIT     = 600000;   // cycles before giving up
    localparam int  KB        = 30;
    localparam int  FB        = 14;

    typedef struct {
        logic signed [15:0] x, y, z, w;
        logic               deg;
    } t_quat;

    // one directed row; the expected quaternion is typed in only where obvious
    typedef struct {
        int   fx, fy, fz, ux, uy, uz;
        bit   known;
        int   ex, ey, ez, ew;
        bit   ed;
    } t_look_row;

    logic               i_clk, i_rst_n;
    logic               i_valid, i_stall;
    logic               o_stall, o_valid, o_degenerate;
    logic signed [15:0] i_fwd_x, i_fwd_y, i_fwd_z, i_up_x, i_up_y, i_up_z;
    logic signed [15:0] o_quat_x, o_quat_y, o_quat_z, o_quat_w;

    t_quat quat_q[$];        // quaternions waiting to come out, oldest first
    int    n_bad, n_seen, n_degen, cycles;
    bit    quiet;

    look_direction_to_quaternion_top #(.IN_WIDTH(16), .FRAC_BITS(14)) DUT (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // fixed-point look rotation predictor, 30 fraction bits inside
    // ------------------------------------------------------------------
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned magn(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint round_div(longint num, longint unsigned den);
        longint unsigned q;
        q = (magn(num) + den / 2) / den;
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    // unit vector: align the largest magnitude to [2^30, 2^31), then divide by length
    function automatic void unit_vec(input longint v[3], output longint o[3]);
        longint unsigned m[3], mx, sum, len, q;
        mx = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = magn(v[i]);
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            o = '{0, 0, 0};
            return;
        end
        while (mx >= 64'd1 << 31) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        while (mx < 64'd1 << 30) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        for (int i = 0; i < 3; i++) sum += m[i] * m[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << KB) + len / 2) / len;
            o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic void cross_prod(input longint a[3], input longint b[3],
                                       output longint o[3]);
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // round to Q1.14 and saturate at +-1.0
    function automatic logic signed [15:0] to_q14(longint v);
        longint unsigned m;
        m = (magn(v) + (64'd1 << (KB - FB - 1))) >> (KB - FB);
        if (m > (64'd1 << FB)) m = 64'd1 << FB;
        return v < 0 ? -16'(m) : 16'(m);
    endfunction

    function automatic longint unsigned pivot_root(longint rad);
        longint unsigned n;
        if (rad < 0) rad = 0;
        n = int_sqrt(longint'(rad) << KB);
        return n == 0 ? 1 : n;
    endfunction

    function automatic t_quat look_rotation(int fx, int fy, int fz,
                                            int ux, int uy, int uz);
        longint f[3], u[3], c[3], fh[3], rh[3], r[3], uh[3];
        longint m00, m01, m02, m10, m11, m12, m20, m21, m22, tr;
        longint qx, qy, qz, qw, one;
        longint unsigned n, den;
        t_quat res;
        one = longint'(1) << KB;
        f = '{fx, fy, fz};
        u = '{ux, uy, uz};
        cross_prod(u, f, c);
        // zero forward, or up zero / parallel: identity with the flag
        if ((f[0] == 0 && f[1] == 0 && f[2] == 0) ||
            (c[0] == 0 && c[1] == 0 && c[2] == 0)) begin
            res = '{x: 0, y: 0, z: 0, w: 16'sd16384, deg: 1'b1};
            return res;
        end
        unit_vec(f, fh);
        unit_vec(c, rh);
        cross_prod(fh, rh, r);
        unit_vec(r, uh);
        m00 = rh[0]; m01 = rh[1]; m02 = rh[2];
        m10 = uh[0]; m11 = uh[1]; m12 = uh[2];
        m20 = fh[0]; m21 = fh[1]; m22 = fh[2];
        tr = m00 + m11 + m22;
        if (tr > 0) begin
            n = pivot_root(tr + one);
            den = 2 * n;
            qw = longint'((n + 1) >> 1);
            qx = round_div((m12 - m21) * one, den);
            qy = round_div((m20 - m02) * one, den);
            qz = round_div((m01 - m10) * one, den);
        end else if (m00 >= m11 && m00 >= m22) begin
            n = pivot_root(one + m00 - m11 - m22);
            den = 2 * n;
            qx = longint'((n + 1) >> 1);
            qy = round_div((m01 + m10) * one, den);
            qz = round_div((m02 + m20) * one, den);
            qw = round_div((m12 - m21) * one, den);
        end else if (m11 > m22) begin
            n = pivot_root(one + m11 - m00 - m22);
            den = 2 * n;
            qx = round_div((m10 + m01) * one, den);
            qy = longint'((n + 1) >> 1);
            qz = round_div((m21 + m12) * one, den);
            qw = round_div((m20 - m02) * one, den);
        end else begin
            n = pivot_root(one + m22 - m00 - m11);
            den = 2 * n;
            qx = round_div((m20 + m02) * one, den);
            qy = round_div((m21 + m12) * one, den);
            qz = longint'((n + 1) >> 1);
            qw = round_div((m01 - m10) * one, den);
        end
        res = '{x: to_q14(qx), y: to_q14(qy), z: to_q14(qz), w: to_q14(qw), deg: 1'b0};
        return res;
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // drive one beat at the falling edge, hold it until taken
    task automatic send_beat(int fx, int fy, int fz, int ux, int uy, int uz, t_quat q);
        i_valid <= 1'b1;
        i_fwd_x <= 16'(fx); i_fwd_y <= 16'(fy); i_fwd_z <= 16'(fz);
        i_up_x  <= 16'(ux); i_up_y  <= 16'(uy); i_up_z  <= 16'(uz);
        do @(posedge i_clk); while (o_stall);
        quat_q.push_back(q);
        @(negedge i_clk);
    endtask

    // random idle burst on the input side, never during the quiet tail
    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
    endtask

    function automatic int rand_in(int lo, int hi);
        return int'($urandom_range(hi - lo)) + lo;
    endfunction

    t_look_row look_tbl[] = '{
        // plain look along +z with +y up: identity, not degenerate
        '{0, 0, 1, 0, 1, 0, 1, 0, 0, 0, 16384, 0},
        // zero forward
        '{0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 16384, 1},
        // zero up
        '{1, 2, 3, 0, 0, 0, 1, 0, 0, 0, 16384, 1},
        // both zero
        '{0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 16384, 1},
        // up parallel to forward
        '{3, -5, 7, 6, -10, 14, 1, 0, 0, 0, 16384, 1},
        // antiparallel at the extremes
        '{-32768, -32768, -32768, 32767, 32767, 32767, 1, 0, 0, 0, 16384, 1},
        // remaining rows go through the predictor, covering each branch
        '{0, 0, -1, 0, 1, 0, 0, 0, 0, 0, 0, 0},
        '{1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0},
        '{-1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0},
        '{0, 1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0},
        '{0, -1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0},
        '{32767, -32768, 1, -32768, 32767, 0, 0, 0, 0, 0, 0, 0},
        '{32767, 0, 0, 0, 32767, 0, 0, 0, 0, 0, 0, 0},
        '{-32768, 0, 0, 0, -32768, 0, 0, 0, 0, 0, 0, 0},
        '{1, 1, 1, -1, 1, -1, 0, 0, 0, 0, 0, 0},
        '{0, 0, -32768, 32767, 0, 0, 0, 0, 0, 0, 0, 0},
        '{100, -3, -2, 1, 1, 1, 0, 0, 0, 0, 0, 0},
        '{1, 0, -1, 0, 1, 0, 0, 0, 0, 0, 0, 0},
        '{0, 1, -1, 1, 0, 0, 0, 0, 0, 0, 0, 0},
        '{12345, -23456, 30000, -1, 2, -3, 0, 0, 0, 0, 0, 0},
        // forward nearly against up
        '{0, -32767, 1, 0, 32767, 0, 0, 0, 0, 0, 0, 0},
        '{-32768, -32768, -32768, -32768, 32767, -32768, 0, 0, 0, 0, 0, 0}
    };

    initial begin
        int    f[3], u[3], k, kind;
        t_quat q;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_fwd_x = '0; i_fwd_y = '0; i_fwd_z = '0;
        i_up_x  = '0; i_up_y  = '0; i_up_z  = '0;
        quiet = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        foreach (look_tbl[r]) begin
            if (look_tbl[r].known)
                q = '{x: 16'(look_tbl[r].ex), y: 16'(look_tbl[r].ey), z: 16'(look_tbl[r].ez),
                      w: 16'(look_tbl[r].ew), deg: look_tbl[r].ed};
            else
                q = look_rotation(look_tbl[r].fx, look_tbl[r].fy, look_tbl[r].fz,
                                  look_tbl[r].ux, look_tbl[r].uy, look_tbl[r].uz);
            send_beat(look_tbl[r].fx, look_tbl[r].fy, look_tbl[r].fz,
                      look_tbl[r].ux, look_tbl[r].uy, look_tbl[r].uz, q);
            maybe_gap();
        end

        // random vector pairs
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n >= N_RANDOM - QUIET_TAIL) quiet = 1'b1;
            // drain the pipe completely once in the middle
            if (n == N_RANDOM / 2) begin
                i_valid <= 1'b0;
                wait (quat_q.size() == 0);
                @(negedge i_clk);
            end
            kind = $urandom_range(0, 9);
            for (int i = 0; i < 3; i++) begin
                case (kind)
                    6: begin
                        f[i] = rand_in(-8, 8);
                        u[i] = rand_in(-8, 8);
                    end
                    9: begin
                        // axis-heavy, large magnitudes
                        f[i] = ($urandom_range(0, 2) == 0) ? rand_in(-32768, 32767) : 0;
                        u[i] = ($urandom_range(0, 2) == 0) ? rand_in(-32768, 32767) : 0;
                    end
                    default: begin
                        f[i] = rand_in(-32768, 32767);
                        u[i] = rand_in(-32768, 32767);
                    end
                endcase
            end
            if (kind == 7) begin
                // up along forward, scaled
                k = rand_in(-3, 3);
                for (int i = 0; i < 3; i++) begin
                    f[i] = rand_in(-10000, 10000);
                    u[i] = f[i] * k;
                end
            end else if (kind == 8) begin
                if ($urandom_range(0, 1)) f = '{0, 0, 0};
                else u = '{0, 0, 0};
            end
            q = look_rotation(f[0], f[1], f[2], u[0], u[1], u[2]);
            send_beat(f[0], f[1], f[2], u[0], u[1], u[2], q);
            maybe_gap();
        end
        i_valid <= 1'b0;

        wait (quat_q.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        $display("%0d quaternions checked, %0d of them degenerate (zero or parallel input)",
                 n_seen, n_degen);
        if (n_bad == 0) begin
            $display("look_direction_to_quaternion_top: match");
        end else begin
            $display("%0d mismatching beats", n_bad);
            $display("look_direction_to_quaternion_top: mismatch");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // output side: random stall bursts, none in the quiet tail
    // ------------------------------------------------------------------
    initial begin
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 4) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // compare each output beat with the oldest waiting quaternion
    always @(posedge i_clk) begin
        t_quat e;
        if (i_rst_n && o_valid && !i_stall) begin
            n_seen++;
            if (o_degenerate) n_degen++;
            if (quat_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("output beat with nothing expected");
            end else begin
                e = quat_q.pop_front();
                if (o_quat_x !== e.x || o_quat_y !== e.y || o_quat_z !== e.z ||
                    o_quat_w !== e.w || o_degenerate !== e.deg) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display({"beat %0d: expected x %0d y %0d z %0d w %0d deg %0b,",
                                  " got x %0d y %0d z %0d w %0d deg %0b"},
                                 n_seen, e.x, e.y, e.z, e.w, e.deg,
                                 o_quat_x, o_quat_y, o_quat_z, o_quat_w, o_degenerate);
                end
            end
        end
    end

    // watchdog
    initial begin
        n_bad = 0;
        n_seen = 0;
        n_degen = 0;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("timeout after %0d cycles, %0d beats outstanding",
                         cycles, quat_q.size());
                $display("look_direction_to_quaternion_top: mismatch");
                $finish;
            end
        end
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ldq_pkg.sv
rtl/ldq_norm3.sv
rtl/look_direction_to_quaternion_top.sv
dv/tb.sv
